@@ sv/ufc_pkg.sv @@
// ----------------------------------------------------------------------------
// ufc_pkg
// shared widths, codes and types of the union-find engine
// ----------------------------------------------------------------------------
package ufc_pkg;

    localparam int MAX_NODES = 4096;
    localparam int NODE_W    = 12;
    localparam int CNT_W     = 13;
    localparam int RANK_W    = 4;

    localparam logic [RANK_W-1:0] RANK_MAX         = RANK_W'(15);
    localparam logic [CNT_W-1:0]  NODE_COUNT_RESET = CNT_W'(MAX_NODES);

    localparam logic CMD_CLEAR = 1'b0;
    localparam logic CMD_UNION = 1'b1;

    typedef struct packed {
        logic [NODE_W-1:0] parent;
        logic [RANK_W-1:0] rank;
        logic [CNT_W-1:0]  count;
    } entry_t;

    typedef struct packed {
        logic              cmd;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [CNT_W-1:0]  limit;
    } req_t;

    typedef struct packed {
        logic              merged;
        logic [NODE_W-1:0] root;
        logic [CNT_W-1:0]  group_size;
        logic [CNT_W-1:0]  largest;
    } res_t;

endpackage

@@ sv/ufc_ram.sv @@
// ----------------------------------------------------------------------------
// ufc_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ufc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/ufc_core.sv @@
// ----------------------------------------------------------------------------
// ufc_core
// find / compress / link sequencer around the node store
// ----------------------------------------------------------------------------
module ufc_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          req_valid,
    output logic          req_ready,
    input  ufc_pkg::req_t req,
    output logic          res_valid,
    input  logic          res_ready,
    output ufc_pkg::res_t res
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLEAR    = 4'd1;
    localparam logic [3:0] S_WALK     = 4'd2;
    localparam logic [3:0] S_WALK_CHK = 4'd3;
    localparam logic [3:0] S_COMP     = 4'd4;
    localparam logic [3:0] S_COMP_CHK = 4'd5;
    localparam logic [3:0] S_LINK0    = 4'd6;
    localparam logic [3:0] S_LINK1    = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0]                   state_reg;
    logic [ufc_pkg::NODE_W-1:0]   sweep_reg;
    logic                         clr_cmd_reg;
    logic                         sel_reg;
    logic [ufc_pkg::NODE_W-1:0]   cur_reg;
    logic [ufc_pkg::NODE_W-1:0]   start_reg;
    logic [ufc_pkg::NODE_W-1:0]   x_reg;
    logic [ufc_pkg::NODE_W-1:0]   b_node_reg;
    logic [ufc_pkg::NODE_W-1:0]   ra_reg;
    logic [ufc_pkg::RANK_W-1:0]   rank_a_reg;
    logic [ufc_pkg::CNT_W-1:0]    cnt_a_reg;
    logic [ufc_pkg::RANK_W-1:0]   root_rank_reg;
    logic [ufc_pkg::CNT_W-1:0]    root_cnt_reg;
    logic [ufc_pkg::CNT_W-1:0]    largest_reg;
    ufc_pkg::res_t                res_reg;

    logic                         wr_en;
    logic [ufc_pkg::NODE_W-1:0]   wr_addr;
    ufc_pkg::entry_t              wr_data;
    logic                         rd_en;
    logic [ufc_pkg::NODE_W-1:0]   rd_addr;
    ufc_pkg::entry_t              rd_data;

    logic                         a_over;
    logic [ufc_pkg::CNT_W-1:0]    sum;
    logic [ufc_pkg::RANK_W-1:0]   new_rank;
    logic                         out_of_use;

    ufc_ram #(
        .WIDTH ($bits(ufc_pkg::entry_t)),
        .DEPTH (ufc_pkg::MAX_NODES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign a_over     = rank_a_reg > root_rank_reg;
    assign sum        = cnt_a_reg + root_cnt_reg;
    assign new_rank   = (rank_a_reg == root_rank_reg && root_rank_reg != ufc_pkg::RANK_MAX)
                        ? root_rank_reg + ufc_pkg::RANK_W'(1) : root_rank_reg;
    assign out_of_use = ({1'b0, req.node_a} >= req.limit) || ({1'b0, req.node_b} >= req.limit);

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // memory port steering
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = sweep_reg;
        wr_data = '{parent: sweep_reg, rank: '0, count: ufc_pkg::CNT_W'(1)};
        rd_en   = 1'b0;
        rd_addr = cur_reg;
        case (state_reg)
            S_CLEAR: begin
                wr_en = 1'b1;
            end
            S_WALK: begin
                rd_en = 1'b1;
            end
            S_WALK_CHK: begin
                if (rd_data.parent != cur_reg) begin
                    rd_en   = 1'b1;
                    rd_addr = rd_data.parent;
                end
            end
            S_COMP: begin
                if (x_reg != cur_reg) begin
                    rd_en   = 1'b1;
                    rd_addr = x_reg;
                end
            end
            S_COMP_CHK: begin
                wr_en   = 1'b1;
                wr_addr = x_reg;
                wr_data = '{parent: cur_reg, rank: rd_data.rank, count: rd_data.count};
            end
            S_LINK0: begin
                if (ra_reg != cur_reg) begin
                    wr_en = 1'b1;
                    if (a_over) begin
                        wr_addr = cur_reg;
                        wr_data = '{parent: ra_reg, rank: root_rank_reg, count: root_cnt_reg};
                    end else begin
                        wr_addr = ra_reg;
                        wr_data = '{parent: cur_reg, rank: rank_a_reg, count: cnt_a_reg};
                    end
                end
            end
            S_LINK1: begin
                wr_en = 1'b1;
                if (a_over) begin
                    wr_addr = ra_reg;
                    wr_data = '{parent: ra_reg, rank: rank_a_reg, count: sum};
                end else begin
                    wr_addr = cur_reg;
                    wr_data = '{parent: cur_reg, rank: new_rank, count: sum};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            sweep_reg   <= '0;
            clr_cmd_reg <= 1'b0;
            sel_reg     <= 1'b0;
            largest_reg <= ufc_pkg::CNT_W'(1);
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (req_valid) begin
                        if (req.cmd == ufc_pkg::CMD_CLEAR) begin
                            sweep_reg   <= '0;
                            clr_cmd_reg <= 1'b1;
                            state_reg   <= S_CLEAR;
                        end else if (out_of_use) begin
                            res_reg   <= '{merged: 1'b0, root: '0, group_size: '0,
                                           largest: largest_reg};
                            state_reg <= S_DONE;
                        end else begin
                            sel_reg    <= 1'b0;
                            cur_reg    <= req.node_a;
                            start_reg  <= req.node_a;
                            b_node_reg <= req.node_b;
                            state_reg  <= S_WALK;
                        end
                    end
                end
                S_CLEAR: begin
                    sweep_reg <= sweep_reg + ufc_pkg::NODE_W'(1);
                    if (sweep_reg == ufc_pkg::NODE_W'(ufc_pkg::MAX_NODES - 1)) begin
                        largest_reg <= ufc_pkg::CNT_W'(1);
                        clr_cmd_reg <= 1'b0;
                        if (clr_cmd_reg) begin
                            res_reg   <= '{merged: 1'b0, root: '0,
                                           group_size: ufc_pkg::CNT_W'(1),
                                           largest: ufc_pkg::CNT_W'(1)};
                            state_reg <= S_DONE;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_WALK: begin
                    state_reg <= S_WALK_CHK;
                end
                S_WALK_CHK: begin
                    if (rd_data.parent == cur_reg) begin
                        root_rank_reg <= rd_data.rank;
                        root_cnt_reg  <= rd_data.count;
                        x_reg         <= start_reg;
                        state_reg     <= S_COMP;
                    end else begin
                        cur_reg <= rd_data.parent;
                    end
                end
                S_COMP: begin
                    if (x_reg != cur_reg) begin
                        state_reg <= S_COMP_CHK;
                    end else if (!sel_reg) begin
                        // root of node_a settled, go after node_b
                        ra_reg     <= cur_reg;
                        rank_a_reg <= root_rank_reg;
                        cnt_a_reg  <= root_cnt_reg;
                        sel_reg    <= 1'b1;
                        cur_reg    <= b_node_reg;
                        start_reg  <= b_node_reg;
                        state_reg  <= S_WALK;
                    end else begin
                        state_reg <= S_LINK0;
                    end
                end
                S_COMP_CHK: begin
                    x_reg     <= rd_data.parent;
                    state_reg <= S_COMP;
                end
                S_LINK0: begin
                    if (ra_reg == cur_reg) begin
                        res_reg   <= '{merged: 1'b0, root: ra_reg, group_size: cnt_a_reg,
                                       largest: largest_reg};
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_LINK1;
                    end
                end
                S_LINK1: begin
                    if (sum > largest_reg) begin
                        largest_reg <= sum;
                    end
                    res_reg   <= '{merged: 1'b1, root: a_over ? ra_reg : cur_reg,
                                   group_size: sum,
                                   largest: (sum > largest_reg) ? sum : largest_reg};
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_valid && req_ready) |=> (state_reg != S_IDLE))
        else $error("core did not leave idle after an accepted transfer");

    a_largest_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_CLEAR) |-> (largest_reg != '0))
        else $error("largest group size dropped to zero");

    a_merged_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.merged) |-> (res.group_size >= ufc_pkg::CNT_W'(2)))
        else $error("merged group smaller than two");

    a_merged_largest: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.merged) |-> (res.largest >= res.group_size))
        else $error("largest below merged group size");

    a_no_write_during_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK || state_reg == S_WALK_CHK) |-> !wr_en)
        else $error("store written while a root walk is reading");

endmodule

@@ sv/union_find_components.sv @@
// ----------------------------------------------------------------------------
// union_find_components
// disjoint-set engine with union by rank and full path compression
// ----------------------------------------------------------------------------
// One command is worked at a time; the node store is a single memory with one
// write and one read port, and its registered reads set the pace. A union
// walks from node_a and from node_b to their roots, over paths of at most
// about log2 of the node count under union by rank, compresses both paths
// and links the two roots; when both nodes already share a group no link is
// written. A union with an index out of use leaves the store alone. A clear
// command sweeps all 4096 entries; the same sweep runs after reset, during
// which s_ready stays low. cfg_ready is always high; node_count must be
// written only while the block is idle, which the block itself does not
// enforce. A finished result waits in the output register while the engine
// goes back to idle.
// ----------------------------------------------------------------------------
module union_find_components (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ufc_pkg::CNT_W-1:0]  cfg_data,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_cmd,
    input  logic [ufc_pkg::NODE_W-1:0] s_node_a,
    input  logic [ufc_pkg::NODE_W-1:0] s_node_b,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_merged,
    output logic [ufc_pkg::NODE_W-1:0] m_root,
    output logic [ufc_pkg::CNT_W-1:0]  m_group_size,
    output logic [ufc_pkg::CNT_W-1:0]  m_largest
);

    logic [ufc_pkg::CNT_W-1:0] node_count_reg;
    logic [ufc_pkg::CNT_W-1:0] limit;
    ufc_pkg::req_t             req;
    ufc_pkg::res_t             res;
    logic                      res_valid;
    logic                      res_ready;
    logic                      m_valid_reg;
    ufc_pkg::res_t             m_res_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= ufc_pkg::NODE_COUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            node_count_reg <= cfg_data;
        end
    end

    // zero acts as one, anything above the store depth as the depth
    always_comb begin
        limit = node_count_reg;
        if (node_count_reg == '0) begin
            limit = ufc_pkg::CNT_W'(1);
        end else if (node_count_reg > ufc_pkg::CNT_W'(ufc_pkg::MAX_NODES)) begin
            limit = ufc_pkg::CNT_W'(ufc_pkg::MAX_NODES);
        end
    end

    assign req = '{cmd: s_cmd, node_a: s_node_a, node_b: s_node_b, limit: limit};

    ufc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_merged     = m_res_reg.merged;
    assign m_root       = m_res_reg.root;
    assign m_group_size = m_res_reg.group_size;
    assign m_largest    = m_res_reg.largest;

endmodule

@@ tb/union_find_components_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_components_checker
// Watches the command, configuration and result channels of the union-find
// engine. Keeps its own disjoint-set store and node count, and works out the
// answer of every accepted command. Each result transfer is compared field by
// field with the oldest outstanding answer. Reports the number of answers
// still outstanding and the number of failures.
// ----------------------------------------------------------------------------
module union_find_components_checker (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [ufc_pkg::CNT_W-1:0]  cfg_data,

    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic                       s_cmd,
    input  logic [ufc_pkg::NODE_W-1:0] s_node_a,
    input  logic [ufc_pkg::NODE_W-1:0] s_node_b,

    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic                       m_merged,
    input  logic [ufc_pkg::NODE_W-1:0] m_root,
    input  logic [ufc_pkg::CNT_W-1:0]  m_group_size,
    input  logic [ufc_pkg::CNT_W-1:0]  m_largest,

    output int                         pending,
    output int                         failures
);

    logic [ufc_pkg::NODE_W-1:0] link_to [ufc_pkg::MAX_NODES];
    logic [ufc_pkg::RANK_W-1:0] height  [ufc_pkg::MAX_NODES];
    logic [ufc_pkg::CNT_W-1:0]  members [ufc_pkg::MAX_NODES];
    logic [ufc_pkg::CNT_W-1:0]  biggest;
    logic [ufc_pkg::CNT_W-1:0]  count_reg;

    ufc_pkg::res_t predicted_answers [$];
    int            fail_count = 0;

    assign failures = fail_count;

    function automatic void wipe_sets();
        for (int i = 0; i < ufc_pkg::MAX_NODES; i++) begin
            link_to[i] = ufc_pkg::NODE_W'(i);
            height[i]  = '0;
            members[i] = ufc_pkg::CNT_W'(1);
        end
        biggest = ufc_pkg::CNT_W'(1);
    endfunction

    // find with full path compression
    function automatic logic [ufc_pkg::NODE_W-1:0] chase_root(
        input logic [ufc_pkg::NODE_W-1:0] start);
        logic [ufc_pkg::NODE_W-1:0] head;
        logic [ufc_pkg::NODE_W-1:0] walk;
        logic [ufc_pkg::NODE_W-1:0] hop;
        int                         steps;
        head  = start;
        steps = 0;
        while (link_to[head] != head && steps < ufc_pkg::MAX_NODES) begin
            head = link_to[head];
            steps++;
        end
        walk  = start;
        steps = 0;
        while (walk != head && steps < ufc_pkg::MAX_NODES) begin
            hop           = link_to[walk];
            link_to[walk] = head;
            walk          = hop;
            steps++;
        end
        return head;
    endfunction

    function automatic ufc_pkg::res_t apply_command(input logic cmd,
                                                    input logic [ufc_pkg::NODE_W-1:0] a,
                                                    input logic [ufc_pkg::NODE_W-1:0] b);
        ufc_pkg::res_t              ans;
        logic [ufc_pkg::CNT_W-1:0]  lim;
        logic [ufc_pkg::NODE_W-1:0] ra;
        logic [ufc_pkg::NODE_W-1:0] rb;
        logic [ufc_pkg::NODE_W-1:0] head;
        ans = '0;
        if (count_reg == '0) begin
            lim = ufc_pkg::CNT_W'(1);
        end else if (count_reg > ufc_pkg::NODE_COUNT_RESET) begin
            lim = ufc_pkg::NODE_COUNT_RESET;
        end else begin
            lim = count_reg;
        end
        if (cmd == ufc_pkg::CMD_CLEAR) begin
            wipe_sets();
            ans.group_size = ufc_pkg::CNT_W'(1);
            ans.largest    = ufc_pkg::CNT_W'(1);
            return ans;
        end
        // index out of use leaves the store alone
        if (ufc_pkg::CNT_W'(a) >= lim || ufc_pkg::CNT_W'(b) >= lim) begin
            ans.largest = biggest;
            return ans;
        end
        ra   = chase_root(a);
        rb   = chase_root(b);
        head = ra;
        if (ra != rb) begin
            ans.merged = 1'b1;
            if (height[ra] > height[rb]) begin
                link_to[rb] = ra;
                head        = ra;
            end else begin
                link_to[ra] = rb;
                if (height[ra] == height[rb] && height[rb] < ufc_pkg::RANK_MAX) begin
                    height[rb] = height[rb] + ufc_pkg::RANK_W'(1);
                end
                head = rb;
            end
            members[head] = members[ra] + members[rb];
            if (members[head] > biggest) begin
                biggest = members[head];
            end
        end
        ans.root       = head;
        ans.group_size = members[head];
        ans.largest    = biggest;
        return ans;
    endfunction

    task automatic check_field(input string field, input logic [ufc_pkg::CNT_W-1:0] want,
                               input logic [ufc_pkg::CNT_W-1:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0d, got %0d", field, want, seen);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        ufc_pkg::res_t want;
        if (!aresetn) begin
            count_reg = ufc_pkg::NODE_COUNT_RESET;
            wipe_sets();
            predicted_answers.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_answers.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    fail_count++;
                end else begin
                    want = predicted_answers.pop_front();
                    check_field("merged", ufc_pkg::CNT_W'(want.merged),
                                ufc_pkg::CNT_W'(m_merged));
                    check_field("root", ufc_pkg::CNT_W'(want.root), ufc_pkg::CNT_W'(m_root));
                    check_field("group_size", want.group_size, m_group_size);
                    check_field("largest", want.largest, m_largest);
                end
            end
            if (cfg_valid && cfg_ready) begin
                count_reg = cfg_data;
            end
            if (s_valid && s_ready) begin
                predicted_answers.push_back(apply_command(s_cmd, s_node_a, s_node_b));
            end
        end
        pending <= predicted_answers.size();
    end

endmodule

@@ tb/union_find_components_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_components_test
// Top of the union-find engine testbench. Drives a directed run through
// merges, same-group unions, indices out of use, shrunk and out-of-range node
// counts and clears, then random phases of union traffic at several node
// counts and idling mixes on both channels. The checker beside the engine
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module union_find_components_test;

    localparam int CYCLE_LIMIT     = 2000000;
    localparam int PHASE_COUNT     = 10;
    localparam int ITEMS_PER_PHASE = 190;

    logic                       aclk;
    logic                       aresetn      = 1'b0;
    logic                       cfg_valid    = 1'b0;
    logic                       cfg_ready;
    logic [ufc_pkg::CNT_W-1:0]  cfg_data     = '0;
    logic                       s_valid      = 1'b0;
    logic                       s_ready;
    logic                       s_cmd        = ufc_pkg::CMD_CLEAR;
    logic [ufc_pkg::NODE_W-1:0] s_node_a     = '0;
    logic [ufc_pkg::NODE_W-1:0] s_node_b     = '0;
    logic                       m_valid;
    logic                       m_ready      = 1'b0;
    logic                       m_merged;
    logic [ufc_pkg::NODE_W-1:0] m_root;
    logic [ufc_pkg::CNT_W-1:0]  m_group_size;
    logic [ufc_pkg::CNT_W-1:0]  m_largest;

    int pending;
    int failures;
    int cycle_count = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int use_limit   = ufc_pkg::MAX_NODES;

    int count_plan [PHASE_COUNT] = '{16, 4096, 1, 200, 8191, 0, 64, 2, 4096, 37};
    int idle_plan  [4]           = '{0, 49, 0, 14};
    int stall_plan [4]           = '{0, 0, 49, 14};

    union_find_components dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_node_a     (s_node_a),
        .s_node_b     (s_node_b),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_merged     (m_merged),
        .m_root       (m_root),
        .m_group_size (m_group_size),
        .m_largest    (m_largest)
    );

    union_find_components_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_node_a     (s_node_a),
        .s_node_b     (s_node_b),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_merged     (m_merged),
        .m_root       (m_root),
        .m_group_size (m_group_size),
        .m_largest    (m_largest),
        .pending      (pending),
        .failures     (failures)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("union_find_components_test: errors");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // returns with s_valid still high at the edge of the transfer
    task automatic send_item(input logic cmd, input logic [ufc_pkg::NODE_W-1:0] a,
                             input logic [ufc_pkg::NODE_W-1:0] b);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_cmd    <= cmd;
        s_node_a <= a;
        s_node_b <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic set_count(input int value);
        s_valid <= 1'b0;
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= ufc_pkg::CNT_W'(value);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (value == 0) begin
            use_limit = 1;
        end else if (value > ufc_pkg::MAX_NODES) begin
            use_limit = ufc_pkg::MAX_NODES;
        end else begin
            use_limit = value;
        end
    endtask

    // mostly nodes in use, some anywhere in the index space
    function automatic logic [ufc_pkg::NODE_W-1:0] pick_node();
        int span;
        span = use_limit;
        if (span > 256 && $urandom_range(1) == 0) begin
            span = 256;
        end
        if ($urandom_range(99) < 12) begin
            return ufc_pkg::NODE_W'($urandom_range(ufc_pkg::MAX_NODES - 1));
        end
        return ufc_pkg::NODE_W'($urandom_range(span - 1));
    endfunction

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset count covers the whole store
        send_item(ufc_pkg::CMD_UNION, 0, 1);
        send_item(ufc_pkg::CMD_UNION, 1, 0);
        send_item(ufc_pkg::CMD_UNION, 4095, 4094);
        send_item(ufc_pkg::CMD_UNION, 0, 4095);
        send_item(ufc_pkg::CMD_UNION, 2, 2);
        send_item(ufc_pkg::CMD_UNION, 4095, 1);
        send_item(ufc_pkg::CMD_CLEAR, 4095, 4095);
        send_item(ufc_pkg::CMD_UNION, 0, 1);

        set_count(4);
        send_item(ufc_pkg::CMD_UNION, 3, 2);
        send_item(ufc_pkg::CMD_UNION, 5, 0);
        send_item(ufc_pkg::CMD_UNION, 0, 4095);
        send_item(ufc_pkg::CMD_UNION, 2, 1);
        send_item(ufc_pkg::CMD_UNION, 0, 3);

        // shrunk without clear
        set_count(2);
        send_item(ufc_pkg::CMD_UNION, 1, 0);
        send_item(ufc_pkg::CMD_UNION, 2, 0);

        set_count(0);
        send_item(ufc_pkg::CMD_UNION, 0, 0);
        send_item(ufc_pkg::CMD_UNION, 1, 0);

        set_count(8191);
        send_item(ufc_pkg::CMD_UNION, 4095, 0);
        send_item(ufc_pkg::CMD_CLEAR, 0, 0);
        send_item(ufc_pkg::CMD_UNION, 4095, 4095);

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            set_count(count_plan[ph]);
            idle_pct   = idle_plan[ph % 4];
            stall_pct <= stall_plan[ph % 4];
            if ($urandom_range(2) != 0) begin
                send_item(ufc_pkg::CMD_CLEAR,
                          ufc_pkg::NODE_W'($urandom_range(ufc_pkg::MAX_NODES - 1)),
                          ufc_pkg::NODE_W'($urandom_range(ufc_pkg::MAX_NODES - 1)));
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if ($urandom_range(119) == 0) begin
                    send_item(ufc_pkg::CMD_CLEAR,
                              ufc_pkg::NODE_W'($urandom_range(ufc_pkg::MAX_NODES - 1)),
                              ufc_pkg::NODE_W'($urandom_range(ufc_pkg::MAX_NODES - 1)));
                end else begin
                    send_item(ufc_pkg::CMD_UNION, pick_node(), pick_node());
                end
            end
        end

        s_valid <= 1'b0;
        drain();
        repeat (100) @(posedge aclk);
        if (failures == 0 && pending == 0) begin
            $display("union_find_components_test: clean");
        end else begin
            $display("union_find_components_test: errors");
        end
        $finish;
    end

endmodule
